FILE: sv/rsi_pkg.sv
`default_nettype none

package rsi_pkg;

  localparam int RID_W   = 4;
  localparam int STAMP_W = 48;
  localparam int SUM_W   = 56;
  localparam int CNT_W   = 32;
  localparam int QDEPTH  = 2;
  localparam int REGION_SPACE = 1 << RID_W;

  typedef struct packed {
    logic               in_range;
    logic               is_begin;
    logic [STAMP_W-1:0] timestamp;
    logic [RID_W-1:0]   region_id;
  } item_t;

  typedef struct packed {
    logic               pending;
    logic [STAMP_W-1:0] last_stamp;
    logic [SUM_W-1:0]   sum_time;
    logic [CNT_W-1:0]   closed_count;
    logic [STAMP_W-1:0] shortest;
    logic [STAMP_W-1:0] longest;
  } entry_t;

endpackage

`default_nettype wire

FILE: sv/rsi_front.sv
`default_nettype none

module rsi_front #(
  parameter int NUM_REGIONS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire                          in_is_begin,
  input  wire  [rsi_pkg::STAMP_W-1:0]  in_timestamp,
  input  wire  [rsi_pkg::RID_W-1:0]    in_region_id,
  output logic                         push,
  output rsi_pkg::item_t               push_item,
  input  wire                          queue_full
);
  import rsi_pkg::*;

  logic  hold_vld_r;
  logic  hold_vld_nxt;
  item_t hold_r;
  logic  accept;

  assign push      = hold_vld_r && !queue_full;
  assign push_item = hold_r;
  assign busy      = hold_vld_r && queue_full;
  assign accept    = start && !busy;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (accept) begin
      hold_vld_nxt = 1'b1;
    end else if (push) begin
      hold_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
    end
  end

  // classify the transaction on entry
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r.in_range  <= (32'(in_region_id) < NUM_REGIONS);
      hold_r.is_begin  <= in_is_begin;
      hold_r.timestamp <= in_timestamp;
      hold_r.region_id <= in_region_id;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rsi_queue.sv
`default_nettype none

module rsi_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  rsi_pkg::item_t       push_item,
  output logic                 full,
  input  wire                  pop,
  output rsi_pkg::item_t       pop_item,
  output logic                 empty
);
  import rsi_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W_Q = $clog2(QDEPTH + 1);

  item_t              slot_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W_Q-1:0] fill_r;
  logic [CNT_W_Q-1:0] fill_nxt;

  assign full     = (fill_r == CNT_W_Q'(QDEPTH));
  assign empty    = (fill_r == '0);
  assign pop_item = slot_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

FILE: sv/rsi_divider.sv
`default_nettype none

module rsi_divider (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        div_start,
  input  wire  [rsi_pkg::SUM_W-1:0]  dividend,
  input  wire  [rsi_pkg::CNT_W-1:0]  divisor,
  output logic                       div_done,
  output logic [rsi_pkg::SUM_W-1:0]  quotient
);
  import rsi_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              run_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              ge;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = !diff[CNT_W];

  assign div_done = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: sv/rsi_back.sv
`default_nettype none

module rsi_back #(
  parameter int DEPTH = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          queue_empty,
  input  rsi_pkg::item_t               pop_item,
  output logic                         pop,
  output logic                         out_valid,
  output logic [rsi_pkg::RID_W-1:0]    out_result_region,
  output logic                         out_interval_done,
  output logic [rsi_pkg::STAMP_W-1:0]  out_interval_time,
  output logic [rsi_pkg::CNT_W-1:0]    out_visit_count,
  output logic [rsi_pkg::SUM_W-1:0]    out_total_time,
  output logic [rsi_pkg::STAMP_W-1:0]  out_min_time,
  output logic [rsi_pkg::STAMP_W-1:0]  out_max_time,
  output logic [rsi_pkg::SUM_W-1:0]    out_mean_time
);
  import rsi_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SPAN = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  entry_t             ent_r [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  item_t              item_r;
  entry_t             cur_r;
  logic [STAMP_W-1:0] span_r;
  logic               close_r;
  logic [IDX_W-1:0]   idx;
  entry_t             upd;
  logic [SUM_W:0]     total_wide;
  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   quotient;
  logic               need_div;

  logic [RID_W-1:0]   res_region_r;
  logic               res_done_r;
  logic [STAMP_W-1:0] res_span_r;
  logic [CNT_W-1:0]   res_count_r;
  logic [SUM_W-1:0]   res_total_r;
  logic [STAMP_W-1:0] res_min_r;
  logic [STAMP_W-1:0] res_max_r;
  logic [SUM_W-1:0]   res_mean_r;

  assign idx = IDX_W'(item_r.region_id);
  assign pop = (state_r == S_IDLE) && !queue_empty;

  always_comb begin
    upd        = cur_r;
    total_wide = {1'b0, cur_r.sum_time} + {{(SUM_W + 1 - STAMP_W){1'b0}}, span_r};
    upd.last_stamp = item_r.timestamp;
    if (close_r) begin
      upd.pending = 1'b0;
      if (cur_r.closed_count == '0) begin
        upd.shortest = span_r;
        upd.longest  = span_r;
      end else begin
        if (span_r < cur_r.shortest) begin
          upd.shortest = span_r;
        end
        if (span_r > cur_r.longest) begin
          upd.longest = span_r;
        end
      end
      upd.sum_time = total_wide[SUM_W] ? '1 : total_wide[SUM_W-1:0];
      if (cur_r.closed_count != '1) begin
        upd.closed_count = cur_r.closed_count + 1'b1;
      end
    end else begin
      upd.pending = item_r.is_begin;
    end
  end

  assign need_div  = item_r.in_range && (upd.closed_count != '0);
  assign div_start = (state_r == S_UPD) && need_div;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!queue_empty) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_SPAN;
      S_SPAN: state_nxt = S_UPD;
      S_UPD:  state_nxt = need_div ? S_DIV : S_OUT;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_UPD && item_r.in_range) begin
        vld_r[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= pop_item;
    end
    if (state_r == S_READ) begin
      cur_r <= vld_r[idx] ? ent_r[idx] : '0;
    end
    if (state_r == S_SPAN) begin
      span_r  <= item_r.timestamp - cur_r.last_stamp;
      close_r <= !item_r.is_begin && cur_r.pending;
    end
    if (state_r == S_UPD) begin
      if (item_r.in_range) begin
        ent_r[idx] <= upd;
      end
      res_region_r <= item_r.region_id;
      res_done_r   <= item_r.in_range && close_r;
      res_span_r   <= (item_r.in_range && close_r) ? span_r : '0;
      res_count_r  <= item_r.in_range ? upd.closed_count : '0;
      res_total_r  <= item_r.in_range ? upd.sum_time : '0;
      res_min_r    <= item_r.in_range ? upd.shortest : '0;
      res_max_r    <= item_r.in_range ? upd.longest : '0;
      res_mean_r   <= '0;
    end
    if (state_r == S_DIV && div_done) begin
      res_mean_r <= quotient;
    end
  end

  rsi_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_start (div_start),
    .dividend  (upd.sum_time),
    .divisor   (upd.closed_count),
    .div_done  (div_done),
    .quotient  (quotient)
  );

  assign out_valid         = (state_r == S_OUT);
  assign out_result_region = res_region_r;
  assign out_interval_done = res_done_r;
  assign out_interval_time = res_span_r;
  assign out_visit_count   = res_count_r;
  assign out_total_time    = res_total_r;
  assign out_min_time      = res_min_r;
  assign out_max_time      = res_max_r;
  assign out_mean_time     = res_mean_r;

`ifndef ASSERT_OFF
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");
  a_done_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_interval_done) |-> (out_visit_count != '0))
    else $error("closed interval with zero visit count");
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_visit_count != '0) |-> (out_min_time <= out_max_time))
    else $error("minimum above maximum");
`endif

endmodule

`default_nettype wire

FILE: sv/region_interval_statistics_unit.sv
// from accepted start to out_valid a transaction passes the front register, the queue and the
// back-end states S_READ, S_SPAN, S_UPD, S_DIV (in range, nonzero visit count only) and S_OUT
// the back end takes one transaction at a time and waits on the 56-step divider for the mean;
// a two-entry queue and a front register let up to three transactions wait ahead of it
// the receiver cannot stall; rst_n is synchronous and clears all statistics and queues
`default_nettype none

module region_interval_statistics_unit #(
  parameter int NUM_REGIONS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire                          in_is_begin,
  input  wire  [rsi_pkg::STAMP_W-1:0]  in_timestamp,
  input  wire  [rsi_pkg::RID_W-1:0]    in_region_id,
  output logic                         out_valid,
  output logic [rsi_pkg::RID_W-1:0]    out_result_region,
  output logic                         out_interval_done,
  output logic [rsi_pkg::STAMP_W-1:0]  out_interval_time,
  output logic [rsi_pkg::CNT_W-1:0]    out_visit_count,
  output logic [rsi_pkg::SUM_W-1:0]    out_total_time,
  output logic [rsi_pkg::STAMP_W-1:0]  out_min_time,
  output logic [rsi_pkg::STAMP_W-1:0]  out_max_time,
  output logic [rsi_pkg::SUM_W-1:0]    out_mean_time
);
  import rsi_pkg::*;

  localparam int DEPTH = (NUM_REGIONS < REGION_SPACE) ? NUM_REGIONS : REGION_SPACE;

  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  pop;
  item_t pop_item;
  logic  queue_empty;

  rsi_front #(
    .NUM_REGIONS (NUM_REGIONS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_is_begin  (in_is_begin),
    .in_timestamp (in_timestamp),
    .in_region_id (in_region_id),
    .push         (push),
    .push_item    (push_item),
    .queue_full   (queue_full)
  );

  rsi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (queue_empty)
  );

  rsi_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .queue_empty       (queue_empty),
    .pop_item          (pop_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_result_region (out_result_region),
    .out_interval_done (out_interval_done),
    .out_interval_time (out_interval_time),
    .out_visit_count   (out_visit_count),
    .out_total_time    (out_total_time),
    .out_min_time      (out_min_time),
    .out_max_time      (out_max_time),
    .out_mean_time     (out_mean_time)
  );

endmodule

`default_nettype wire
